// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define SPQ_ASSERT_ALWAYS(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int PRIO_W  = 8;
  localparam int DATA_W  = 16;
  localparam int FILL_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } spq_status_t;

  typedef struct packed {
    spq_op_t           operation;
    logic [PRIO_W-1:0] req_prio;
    logic [DATA_W-1:0] item_data;
  } spq_cmd_t;

  typedef struct packed {
    spq_status_t       status;
    logic [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0] out_priority;
    logic [FILL_W-1:0] fill_level;
  } spq_result_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_entry_t;

  // Broadcast to every cell for the beat being applied.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [PRIO_W-1:0] prio;
  } spq_ctrl_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic       clk,
  input  wire spq_ctrl_t  ctrl,
  input  wire logic [CW-1:0] count,
  input  wire spq_entry_t left_entry,
  input  wire logic       left_ahead,
  input  wire spq_entry_t right_entry,
  output spq_entry_t      entry,
  output logic            ahead
);

  logic occupied;

  assign occupied = (CW'(IDX) < count);
  // Held entry stays in front of a new one of equal or larger number.
  assign ahead    = occupied && (entry.prio <= ctrl.prio);

  always_ff @(posedge clk) begin
    priority if (ctrl.ins) begin
      if (!ahead) begin
        entry <= left_ahead ? left_entry : left_entry;
      end
    end else if (ctrl.del) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
`default_nettype none

// Sorted priority queue of QUEUE_DEPTH entries held in a row of cells,
// head in cell 0. Every cell compares its entry against the new priority
// in parallel, so a command accepted at an edge with start high and busy
// low yields its registered result in the following cycle, shown for
// exactly one cycle with done high, and a new command may be issued in
// every cycle while busy is low. busy is rst registered: it is high while
// rst is held and falls at the first edge that samples rst low.
// The receiver cannot stall: results must be taken as they appear.
// Equal priorities leave in arrival order. A delete on an empty queue
// reports underflow; an insert into a full queue is dropped and reports
// overflow. fill_level is the entry count after the command, low 5 bits.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire spq_cmd_t cmd,
  output logic          busy,
  output logic          done,
  output spq_result_t   result
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  spq_ctrl_t     ctrl;
  spq_entry_t    new_entry;
  spq_entry_t    cell_entry [QUEUE_DEPTH];
  logic          cell_ahead [QUEUE_DEPTH];
  spq_result_t   result_next;

  assign accept = start && !busy;
  assign full   = (count == CW'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  assign new_entry.prio = cmd.req_prio;
  assign new_entry.data = cmd.item_data;

  assign ctrl.ins  = accept && (cmd.operation == OP_INSERT) && !full;
  assign ctrl.del  = accept && (cmd.operation == OP_DELETE) && !empty;
  assign ctrl.prio = cmd.req_prio;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      spq_entry_t l_entry;
      logic       l_ahead;
      spq_entry_t r_entry;

      if (gi == 0) begin : g_head
        assign l_entry = new_entry;
        assign l_ahead = 1'b1;
      end else begin : g_body
        // Left neighbor still in front: this cell is the insert slot.
        assign l_entry = cell_ahead[gi-1] ? new_entry : cell_entry[gi-1];
        assign l_ahead = cell_ahead[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign r_entry = cell_entry[gi];
      end else begin : g_inner
        assign r_entry = cell_entry[gi+1];
      end

      spq_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .count       (count),
        .left_entry  (l_entry),
        .left_ahead  (l_ahead),
        .right_entry (r_entry),
        .entry       (cell_entry[gi]),
        .ahead       (cell_ahead[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.del) begin
      count_next = count - CW'(1);
    end

    result_next.out_data     = '0;
    result_next.out_priority = '0;
    result_next.fill_level   = FILL_W'(count_next);
    unique case (cmd.operation)
      OP_INSERT: begin
        result_next.status = full ? ST_OVERFLOW : ST_INSERTED;
      end
      OP_DELETE: begin
        if (empty) begin
          result_next.status = ST_UNDERFLOW;
        end else begin
          result_next.status       = ST_REMOVED;
          result_next.out_data     = cell_entry[0].data;
          result_next.out_priority = cell_entry[0].prio;
        end
      end
      default: begin
        result_next.status = ST_UNDERFLOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    busy <= rst;
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/spq_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module spq_checker
  import spq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire spq_cmd_t    cmd,
  input wire logic        busy,
  input wire logic        done,
  input wire spq_result_t result
);

  logic accepted;

  assign accepted = start && !busy;

  `SPQ_ASSERT_ALWAYS(a_busy_after_rst, rst, busy, "busy low after reset")
  `SPQ_ASSERT_NEXT(a_done_iff_accept, 1'b1, done == $past(accepted), "done not one beat after command")
  `SPQ_ASSERT_NOW(a_underflow_empty, done && result.status == ST_UNDERFLOW, result.fill_level == '0 && result.out_data == '0 && result.out_priority == '0, "underflow with data or fill")
  `SPQ_ASSERT_NEXT(a_insert_grows, done && accepted && cmd.operation == OP_INSERT, done && (result.status == ST_OVERFLOW || result.fill_level == $past(result.fill_level) + 5'd1), "insert did not grow fill level")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .cmd    (cmd),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== tb/sorted_priority_queue_tb.sv =====
`default_nettype none

module sorted_priority_queue_tb;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int NUM_RANDOM = 700;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_NS = 3_000_000;

  typedef struct {
    spq_cmd_t cmd;
    int       gap;
    bit       wait_empty;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  spq_cmd_t    cmd = '0;
  logic        busy;
  logic        done;
  spq_result_t result;

  beat_t       pending_beats[$];
  spq_result_t expected_results[$];
  int          mismatch_count = 0;

  // Shadow copy of the queue contents, head at index 0.
  logic [PRIO_W-1:0] shadow_prio[DEPTH];
  logic [DATA_W-1:0] shadow_data[DEPTH];
  int                shadow_count = 0;

  sorted_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic spq_result_t apply_to_shadow(spq_cmd_t c);
    spq_result_t r;
    int          pos;
    r = '0;
    if (c.operation == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        // new entry goes behind everything of equal or smaller number
        while (pos < shadow_count && shadow_prio[pos] <= c.req_prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_data[i] = shadow_data[i-1];
        end
        shadow_prio[pos] = c.req_prio;
        shadow_data[pos] = c.item_data;
        shadow_count++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.out_data = shadow_data[0];
        r.out_priority = shadow_prio[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_data[i-1] = shadow_data[i];
        end
        shadow_count--;
        r.status = ST_REMOVED;
      end
    end
    r.fill_level = shadow_count[FILL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic spq_cmd_t random_cmd();
    spq_cmd_t c;
    c.operation = spq_op_t'($urandom_range(0, 1));
    c.req_prio = PRIO_W'($urandom_range(0, 255));
    c.item_data = DATA_W'($urandom_range(0, 65535));
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_beat(input spq_op_t op, input logic [PRIO_W-1:0] prio,
                          input logic [DATA_W-1:0] data, input int gap,
                          input bit wait_empty);
    beat_t b;
    b.cmd.operation = op;
    b.cmd.req_prio = prio;
    b.cmd.item_data = data;
    b.gap = gap;
    b.wait_empty = wait_empty;
    pending_beats.push_back(b);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio(int mode, int base);
    case (mode)
      0: begin
        return PRIO_W'($urandom_range(0, 255));
      end
      1: begin
        return PRIO_W'($urandom_range(0, 3));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: begin
        return PRIO_W'((base + int'($urandom_range(0, 2))) & 8'hFF);
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Driver: one nonblocking write per signal per edge.
  always @(posedge clk) begin
    logic     nxt_start;
    spq_cmd_t nxt_cmd;
    bit       took;
    nxt_start = start;
    nxt_cmd = cmd;
    took = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(apply_to_shadow(cmd));
        took = 1'b1;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        nxt_cmd = random_cmd();
        if (pending_beats.size() > 0) begin
          if (pending_beats[0].gap > 0) begin
            pending_beats[0].gap--;
          end else if (!(pending_beats[0].wait_empty &&
                         (expected_results.size() != 0 || took))) begin
            nxt_cmd = pending_beats[0].cmd;
            nxt_start = 1'b1;
            void'(pending_beats.pop_front());
          end
        end
      end
    end
    start <= nxt_start;
    cmd <= nxt_cmd;
  end

  // Monitor: results cannot be held off, so take one whenever done is up.
  always @(posedge clk) begin
    spq_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d data=%h prio=%h fill=%0d",
                                  result.status, result.out_data, result.out_priority,
                                  result.fill_level));
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result.status, want.status));
        if (result.out_data !== want.out_data)
          report_mismatch($sformatf("out_data %h, expected %h",
                                    result.out_data, want.out_data));
        if (result.out_priority !== want.out_priority)
          report_mismatch($sformatf("out_priority %h, expected %h",
                                    result.out_priority, want.out_priority));
        if (result.fill_level !== want.fill_level)
          report_mismatch($sformatf("fill_level %0d, expected %0d",
                                    result.fill_level, want.fill_level));
      end
    end
  end

  initial begin
    int  generated;
    int  burst_len;
    int  burst_kind;
    int  prio_mode;
    int  prio_base;
    int  insert_pct;
    bit  quiet;
    bit  first_wait;
    spq_cmd_t junk;

    // Directed: underflow, extremes, ordering and ties, drain to underflow.
    junk = random_cmd();
    add_beat(OP_DELETE, junk.req_prio, junk.item_data, 0, 1'b0);
    add_beat(OP_INSERT, 8'hFF, 16'hFFFF, 0, 1'b0);
    add_beat(OP_INSERT, 8'h80, 16'h1111, 0, 1'b0);
    add_beat(OP_INSERT, 8'h80, 16'h2222, 0, 1'b0);
    add_beat(OP_INSERT, 8'h00, 16'h0000, 0, 1'b0);
    add_beat(OP_INSERT, 8'h80, 16'h3333, 0, 1'b0);
    add_beat(OP_INSERT, 8'h7F, 16'hAAAA, 1, 1'b0);
    for (int i = 0; i < 7; i++) begin
      junk = random_cmd();
      add_beat(OP_DELETE, junk.req_prio, junk.item_data, i % 2, 1'b0);
    end

    // Hold off until everything is back, then fill well past full.
    for (int i = 0; i < 24; i++)
      add_beat(OP_INSERT, pick_prio(i % 4, 100), pick_data(), 0, i == 0);

    generated = 24;
    while (generated < NUM_RANDOM) begin
      burst_kind = $urandom_range(0, 2);
      burst_len = $urandom_range(4, 30);
      prio_mode = $urandom_range(0, 3);
      prio_base = $urandom_range(0, 253);
      quiet = ($urandom_range(0, 4) == 0);
      first_wait = ($urandom_range(0, 7) == 0);
      case (burst_kind)
        0: insert_pct = 90;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      for (int i = 0; i < burst_len; i++) begin
        junk = random_cmd();
        if ($urandom_range(0, 99) < insert_pct)
          add_beat(OP_INSERT, pick_prio(prio_mode, prio_base), pick_data(),
                   quiet ? 0 : pick_gap(), first_wait && i == 0);
        else
          add_beat(OP_DELETE, junk.req_prio, junk.item_data,
                   quiet ? 0 : pick_gap(), first_wait && i == 0);
      end
      generated += burst_len;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_tb passed");
    end else begin
      $display("sorted_priority_queue_tb failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("TIMEOUT at %0t ns", $time);
    $display("sorted_priority_queue_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
